// ===== hw/rtl/efr_pkg.sv =====
package efr_pkg;

    localparam int LEN_BITS = 8;
    localparam int LIM_W    = 16;
    localparam logic [LIM_W-1:0] LEN_CAP = LIM_W'((32'd1 << LEN_BITS) - 32'd1);
    localparam int CRC_BYTES = 2;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START   = 3'd0,
        CFG_END     = 3'd1,
        CFG_ESCAPE  = 3'd2,
        CFG_MAX_LEN = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_SHORT     = 3'd2,
        ST_RESTARTED = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] escape_byte;
        logic [7:0] max_frame_len;
    } t_cfg;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/efr_cfg_regs.sv =====
module efr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [efr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    output efr_pkg::t_cfg                 o_cfg
);
    import efr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START:   n_cfg.start_byte    = i_cfg_data;
                CFG_END:     n_cfg.end_byte      = i_cfg_data;
                CFG_ESCAPE:  n_cfg.escape_byte   = i_cfg_data;
                CFG_MAX_LEN: n_cfg.max_frame_len = i_cfg_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= 8'd253;
            r_cfg.end_byte      <= 8'd254;
            r_cfg.escape_byte   <= 8'd255;
            r_cfg.max_frame_len <= 8'd255;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/escaped_frame_receiver_crc16.sv =====
// Byte-stuffed frame receiver with CRC-16/CCITT-FALSE check.
// Input channel: i_in_valid / o_in_stall carry one raw link byte per request
// on i_in_byte. Output channel: o_out_valid / i_out_stall carry one result per
// request: a payload byte (o_is_end low) or an end-of-frame status with the
// payload length (o_is_end high). Config channel: i_cfg_valid / o_cfg_ready
// write register i_cfg_index (0 start, 1 end, 2 escape, 3 max length);
// ready is always high and writes take effect on the next cycle.
// A byte is taken into the input register, and its result then moves into the
// output register. One byte is accepted per cycle while o_in_stall is low;
// each byte is decoded, and the payload byte it releases is folded into the
// CRC, by one byte-parallel step between the input and output registers.
// Payload bytes leave two bytes late, since the last two bytes of a frame are
// held back as its CRC.
// Reset (synchronous, active low) empties both registers, leaves the receiver
// outside a frame and loads the marker registers with 253, 254, 255 and the
// length limit with 255. While i_out_stall holds a result, one more byte is
// taken into the input register; further bytes are then stalled, except
// that bytes causing no result keep flowing.
module escaped_frame_receiver_crc16 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_end,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_frame_len,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import efr_pkg::*;

    t_cfg cfg;

    efr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // frame state
    logic                r_in_frame, n_in_frame;
    logic                r_escaped, n_escaped;
    logic                r_overflowed, n_overflowed;
    logic [7:0]          r_held0, n_held0;
    logic [7:0]          r_held1, n_held1;
    logic [1:0]          r_held_count, n_held_count;
    logic [15:0]         r_crc, n_crc;
    logic [LEN_BITS-1:0] r_byte_count, n_byte_count;

    // output register
    logic       r_out_valid;
    logic       r_is_end, n_is_end;
    logic [7:0] r_payload, n_payload;
    t_status    r_status, n_status;
    logic [7:0] r_len, n_len;

    logic             produce;
    logic             advance;
    logic             out_room;
    logic             in_take;
    logic             is_start, is_endb, is_esc;
    logic [LIM_W-1:0] limit;
    logic             at_limit;
    logic [7:0]       cur_len;

    assign is_start = (r_in_byte == cfg.start_byte);
    assign is_endb  = (r_in_byte == cfg.end_byte);
    assign is_esc   = (r_in_byte == cfg.escape_byte);

    always_comb begin
        limit = LIM_W'(cfg.max_frame_len);
        if (limit < LIM_W'(CRC_BYTES)) begin
            limit = LIM_W'(CRC_BYTES);
        end
        if (limit > LEN_CAP) begin
            limit = LEN_CAP;
        end
    end

    assign at_limit = (LIM_W'(r_byte_count) >= limit);
    assign cur_len  = (LIM_W'(r_byte_count) >= LIM_W'(CRC_BYTES))
                    ? 8'(r_byte_count - LEN_BITS'(CRC_BYTES)) : 8'd0;

    // decode, crc and delay line
    always_comb begin
        logic take;
        n_in_frame   = r_in_frame;
        n_escaped    = r_escaped;
        n_overflowed = r_overflowed;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_held_count = r_held_count;
        n_crc        = r_crc;
        n_byte_count = r_byte_count;
        produce      = 1'b0;
        n_is_end     = 1'b0;
        n_payload    = 8'd0;
        n_status     = ST_OK;
        n_len        = 8'd0;
        take         = 1'b0;

        if (r_in_frame && r_escaped) begin
            n_escaped = 1'b0;
            take      = is_start || is_endb || is_esc;
        end else if (is_start) begin
            if (r_in_frame) begin
                produce  = 1'b1;
                n_is_end = 1'b1;
                n_status = ST_RESTARTED;
                n_len    = cur_len;
            end
            n_in_frame   = 1'b1;
            n_escaped    = 1'b0;
            n_overflowed = 1'b0;
            n_held0      = 8'd0;
            n_held1      = 8'd0;
            n_held_count = 2'd0;
            n_crc        = CRC_INIT;
            n_byte_count = '0;
        end else if (!r_in_frame) begin
            take = 1'b0;
        end else if (is_endb) begin
            n_in_frame = 1'b0;
            produce    = 1'b1;
            n_is_end   = 1'b1;
            n_len      = cur_len;
            if (r_overflowed) begin
                n_status = ST_OVERFLOW;
            end else if (LIM_W'(r_byte_count) < LIM_W'(CRC_BYTES)) begin
                n_status = ST_SHORT;
            end else if ({r_held0, r_held1} == r_crc) begin
                n_status = ST_OK;
            end else begin
                n_status = ST_CRC_ERR;
            end
        end else if (is_esc) begin
            n_escaped = 1'b1;
        end else begin
            take = 1'b1;
        end

        if (take) begin
            if (at_limit) begin
                n_overflowed = 1'b1;
            end else begin
                n_byte_count = r_byte_count + LEN_BITS'(1);
                if (r_held_count < 2'd2) begin
                    if (r_held_count[0]) begin
                        n_held1 = r_in_byte;
                    end else begin
                        n_held0 = r_in_byte;
                    end
                    n_held_count = r_held_count + 2'd1;
                end else begin
                    produce   = 1'b1;
                    n_payload = r_held0;
                    n_crc     = crc_update(r_crc, r_held0);
                    n_held0   = r_held1;
                    n_held1   = r_in_byte;
                end
            end
        end
    end

    assign out_room   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!produce || out_room);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_escaped    <= 1'b0;
            r_overflowed <= 1'b0;
            r_held0      <= 8'd0;
            r_held1      <= 8'd0;
            r_held_count <= 2'd0;
            r_crc        <= CRC_INIT;
            r_byte_count <= '0;
        end else if (advance) begin
            r_in_frame   <= n_in_frame;
            r_escaped    <= n_escaped;
            r_overflowed <= n_overflowed;
            r_held0      <= n_held0;
            r_held1      <= n_held1;
            r_held_count <= n_held_count;
            r_crc        <= n_crc;
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_is_end  <= n_is_end;
            r_payload <= n_payload;
            r_status  <= n_status;
            r_len     <= n_len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_end       = r_is_end;
    assign o_payload_byte = r_payload;
    assign o_frame_status = r_status;
    assign o_frame_len    = r_len;

endmodule

// ===== tb/escaped_frame_receiver_crc16_tb.sv =====
`timescale 1ns / 100ps

module escaped_frame_receiver_crc16_tb;

    import efr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int CRC_LEN = 2;
    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;

    typedef struct {
        logic       is_end;
        logic [7:0] payload;
        t_status    status;
        logic [7:0] len;
    } t_rx_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = 3'b000;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_is_end;
    logic [7:0] o_payload_byte;
    logic [2:0] o_frame_status;
    logic [7:0] o_frame_len;
    logic       o_cfg_ready;

    // receiver-side copy of the framing state
    logic [7:0] cfg_start   = 8'd253;
    logic [7:0] cfg_end     = 8'd254;
    logic [7:0] cfg_escape  = 8'd255;
    logic [7:0] cfg_max_len = 8'd255;
    logic       rx_in_frame = 1'b0;
    logic       rx_escaped  = 1'b0;
    logic       rx_overflow = 1'b0;
    logic [7:0] rx_held [2] = '{8'h00, 8'h00};
    logic [1:0] rx_held_cnt = 2'd0;
    logic [15:0] rx_crc     = CRC_SEED;
    logic [7:0] rx_count    = 8'd0;

    t_rx_result frame_results_q[$];

    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;
    int items_used    = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left     = 0;

    escaped_frame_receiver_crc16 u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_end       (o_is_end),
        .o_payload_byte (o_payload_byte),
        .o_frame_status (o_frame_status),
        .o_frame_len    (o_frame_len),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            if (r[15] ^ b[k]) begin
                r = {r[14:0], 1'b0} ^ CCITT_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic bit is_marker(input logic [7:0] b);
        return (b == cfg_start) || (b == cfg_end) || (b == cfg_escape);
    endfunction

    function automatic logic [7:0] frame_payload_len();
        return (rx_count >= 8'(CRC_LEN)) ? rx_count - 8'(CRC_LEN) : 8'd0;
    endfunction

    function automatic void push_status(input t_status st);
        t_rx_result r;
        r.is_end  = 1'b1;
        r.payload = 8'h00;
        r.status  = st;
        r.len     = frame_payload_len();
        frame_results_q.push_back(r);
    endfunction

    function automatic void open_frame();
        rx_in_frame = 1'b1;
        rx_escaped  = 1'b0;
        rx_overflow = 1'b0;
        rx_held[0]  = 8'h00;
        rx_held[1]  = 8'h00;
        rx_held_cnt = 2'd0;
        rx_crc      = CRC_SEED;
        rx_count    = 8'd0;
    endfunction

    function automatic void take_payload(input logic [7:0] b);
        logic [7:0] lim;
        t_rx_result r;
        lim = (cfg_max_len < 8'(CRC_LEN)) ? 8'(CRC_LEN) : cfg_max_len;
        if (rx_count >= lim) begin
            rx_overflow = 1'b1;
            return;
        end
        rx_count++;
        if (rx_held_cnt < 2'd2) begin
            rx_held[rx_held_cnt[0]] = b;
            rx_held_cnt++;
        end else begin
            r.is_end  = 1'b0;
            r.payload = rx_held[0];
            r.status  = ST_OK;
            r.len     = 8'd0;
            frame_results_q.push_back(r);
            rx_crc     = crc16_step(rx_crc, rx_held[0]);
            rx_held[0] = rx_held[1];
            rx_held[1] = b;
        end
    endfunction

    function automatic void rx_decode(input logic [7:0] b);
        if (rx_in_frame || b == cfg_start) begin
            items_used++;
        end
        if (rx_in_frame && rx_escaped) begin
            rx_escaped = 1'b0;
            if (is_marker(b)) begin
                take_payload(b);
            end
        end else if (b == cfg_start) begin
            if (rx_in_frame) begin
                push_status(ST_RESTARTED);
            end
            open_frame();
        end else if (rx_in_frame) begin
            if (b == cfg_end) begin
                rx_in_frame = 1'b0;
                if (rx_overflow) begin
                    push_status(ST_OVERFLOW);
                end else if (rx_count < 8'(CRC_LEN)) begin
                    push_status(ST_SHORT);
                end else if ({rx_held[0], rx_held[1]} == rx_crc) begin
                    push_status(ST_OK);
                end else begin
                    push_status(ST_CRC_ERR);
                end
            end else if (b == cfg_escape) begin
                rx_escaped = 1'b1;
            end else begin
                take_payload(b);
            end
        end
    endfunction

    // output side: random stall, or a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rx_result want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (frame_results_q.size() == 0) begin
                if (mismatch_cnt < 10) begin
                    $display("unexpected result: end=%0b byte=%02h st=%0d len=%0d",
                             o_is_end, o_payload_byte, o_frame_status, o_frame_len);
                end
                mismatch_cnt++;
            end else begin
                want = frame_results_q.pop_front();
                if (o_is_end !== want.is_end || o_payload_byte !== want.payload ||
                    o_frame_status !== want.status || o_frame_len !== want.len) begin
                    if (mismatch_cnt < 10) begin
                        $display("mismatch: exp end=%0b byte=%02h st=%0d len=%0d, got end=%0b byte=%02h st=%0d len=%0d",
                                 want.is_end, want.payload, want.status, want.len,
                                 o_is_end, o_payload_byte, o_frame_status, o_frame_len);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        rx_decode(b);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_START:   cfg_start   = data;
            CFG_END:     cfg_end     = data;
            CFG_ESCAPE:  cfg_escape  = data;
            CFG_MAX_LEN: cfg_max_len = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255, 0));
        while (is_marker(b)) begin
            b = 8'($urandom_range(255, 0));
        end
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(4, 0))
            0: return cfg_start;
            1: return cfg_end;
            2: return cfg_escape;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // one frame: payload, crc big-endian, markers stuffed
    task automatic send_frame(input logic [7:0] body[$], input bit bad_crc,
                              input bit junk_esc, input bit close);
        logic [15:0] crc;
        logic [7:0] raw[$];
        crc = CRC_SEED;
        foreach (body[i]) begin
            crc = crc16_step(crc, body[i]);
        end
        if (bad_crc) begin
            crc ^= 16'(1 << $urandom_range(15, 0));
        end
        raw = body;
        raw.push_back(crc[15:8]);
        raw.push_back(crc[7:0]);
        send_byte(cfg_start);
        foreach (raw[i]) begin
            if (junk_esc && $urandom_range(3, 0) == 0) begin
                send_byte(cfg_escape);
                send_byte(plain_byte());
            end
            if (is_marker(raw[i])) begin
                send_byte(cfg_escape);
            end
            send_byte(raw[i]);
        end
        if (close) begin
            send_byte(cfg_end);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] body[$];
        int n;
        int kind;
        kind = $urandom_range(99, 0);
        n = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 0);
        repeat (n) body.push_back(8'($urandom_range(255, 0)));
        if (kind < 65) begin
            send_frame(body, 1'b0, 1'b0, 1'b1);
        end else if (kind < 75) begin
            send_frame(body, 1'b1, 1'b0, 1'b1);
        end else if (kind < 85) begin
            send_frame(body, 1'b0, 1'b1, 1'b1);
        end else if (kind < 92) begin
            send_frame(body, 1'b0, 1'b0, 1'b0);
        end else begin
            repeat ($urandom_range(6, 1)) send_byte(noise_byte());
        end
    endtask

    task automatic pick_random_config();
        logic [7:0] s;
        logic [7:0] e;
        logic [7:0] x;
        logic [7:0] ml;
        s = 8'($urandom_range(255, 0));
        do e = 8'($urandom_range(255, 0)); while (e == s);
        do x = 8'($urandom_range(255, 0)); while (x == s || x == e);
        case ($urandom_range(3, 0))
            0: ml = 8'($urandom_range(1, 0));
            1: ml = 8'd255;
            2: ml = 8'($urandom_range(14, 2));
            default: ml = 8'($urandom_range(254, 15));
        endcase
        write_reg(CFG_START, s);
        write_reg(CFG_END, e);
        write_reg(CFG_ESCAPE, x);
        write_reg(CFG_MAX_LEN, ml);
        if ($urandom_range(1, 0) == 1) begin
            write_reg(3'($urandom_range(7, 4)), 8'($urandom_range(255, 0)));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int goal;
        pick_random_config();
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        goal = items_used + n_items;
        while (items_used < goal) begin
            send_random_frame();
        end
    endtask

    task automatic test_idle_and_short_frames();
        send_byte(8'h00);
        send_byte(cfg_end);
        send_byte(cfg_escape);
        send_byte(cfg_start);
        send_byte(cfg_end);
        send_byte(cfg_start);
        send_byte(8'h00);
        send_byte(cfg_end);
    endtask

    task automatic test_escapes_and_crc();
        logic [7:0] body[$];
        body.push_back(cfg_start);
        body.push_back(cfg_end);
        body.push_back(cfg_escape);
        send_frame(body, 1'b0, 1'b0, 1'b1);
        body.delete();
        send_frame(body, 1'b1, 1'b0, 1'b1);
        // dropped escape, then restart mid frame
        send_byte(cfg_start);
        send_byte(8'h11);
        send_byte(cfg_escape);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(8'h55);
        send_byte(cfg_start);
        send_byte(cfg_end);
    endtask

    task automatic test_register_extremes();
        logic [7:0] body[$];
        write_reg(CFG_START, 8'h00);
        write_reg(CFG_END, 8'hFF);
        write_reg(CFG_ESCAPE, 8'h80);
        write_reg(CFG_MAX_LEN, 8'h00);
        body.push_back(8'h01);
        send_frame(body, 1'b0, 1'b0, 1'b1);
        body.delete();
        send_frame(body, 1'b0, 1'b0, 1'b1);
        // end shares its value with escape
        write_reg(CFG_END, 8'h80);
        send_byte(8'h00);
        send_byte(8'h42);
        send_byte(8'h80);
        // start shares its value with escape
        write_reg(CFG_ESCAPE, 8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        write_reg(3'($urandom_range(7, 4)), 8'($urandom_range(255, 0)));
        send_byte(8'h00);
        send_byte(8'h80);
    endtask

    task automatic test_random_frames();
        run_phase(0, 0, 170);
        run_phase(59, 0, 170);
        run_phase(0, 59, 170);
        run_phase(37, 37, 170);
    endtask

    task automatic test_output_hold();
        logic [7:0] body[$];
        write_reg(CFG_START, 8'd253);
        write_reg(CFG_END, 8'd254);
        write_reg(CFG_ESCAPE, 8'd255);
        write_reg(CFG_MAX_LEN, 8'd255);
        send_idle_pct = 0;
        out_stall_pct = 0;
        repeat (253) body.push_back(8'($urandom_range(255, 0)));
        hold_left = 300;
        send_frame(body, 1'b0, 1'b0, 1'b1);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_short_frames();
        test_escapes_and_crc();
        test_register_extremes();
        test_random_frames();
        test_output_hold();
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== escaped_frame_receiver_crc16.f =====
hw/rtl/efr_pkg.sv
hw/rtl/efr_cfg_regs.sv
hw/rtl/escaped_frame_receiver_crc16.sv
tb/escaped_frame_receiver_crc16_tb.sv
